@@ rtl/core/swm_pkg.sv @@
// Shared types and constants for the sliding window maximum block.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

	localparam int SAMPLE_W         = 32;
	localparam int CFG_W            = 6;
	localparam int WINDOW_DEPTH_DEF = 32;
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sample;
		logic    last_sample;
	} swm_in_t;

	typedef struct packed {
		sample_t window_max;
		logic    seq_end;
	} swm_out_t;

	typedef struct packed {
		logic shift;
		logic tap;
	} swm_cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/sliding_window_max.sv @@
// Top level of the sliding window maximum: cell chain, fill count and output register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | in        | in_valid/in_ready  | in_data  (sample, last_sample)
//   out     | out       | out_valid/out_ready| out_data (window_max, seq_end)
//   cfg     | in        | cfg_we             | cfg_wdata (window_size)
//
// One sample per cycle unless a held result stalls input; a result appears in the cycle after its sample is taken.
// Cell k of the chain keeps the maximum of the newest k+1 samples; the
// result is the new sample compared against the cell picked by window_size.
// Reset clears the fill count, the output valid and sets window_size to one.
// A held result stalls input only while out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_max #(
	parameter int WINDOW_DEPTH = swm_pkg::WINDOW_DEPTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [swm_pkg::CFG_W-1:0] cfg_wdata,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  swm_pkg::swm_in_t         in_data,
	output logic                     out_valid,
	input  wire                      out_ready,
	output swm_pkg::swm_out_t        out_data
);
	import swm_pkg::*;

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int N_CELL = WINDOW_DEPTH - 1;

	logic [CFG_W-1:0] ws_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	swm_out_t         out_data_q;

	logic [CMP_W-1:0] ws_ext;
	logic [CNT_W-1:0] ws_eff;
	logic [CNT_W-1:0] cnt_inc;
	logic             accept;
	logic             produce;
	sample_t          x;
	sample_t          tap_or;
	sample_t          result;

	sample_t       cell_m   [N_CELL];
	sample_t       cell_tap [N_CELL];
	swm_cell_ctl_t cell_ctl [N_CELL];

	assign accept   = in_valid & in_ready;
	assign in_ready = ~out_valid_q | out_ready;
	assign x        = in_data.sample;

	// Clamp the window to 1..WINDOW_DEPTH.
	always_comb begin
		ws_ext = CMP_W'(ws_q);
		if (ws_q == '0) begin
			ws_eff = CNT_W'(1);
		end else if (ws_ext > CMP_W'(WINDOW_DEPTH)) begin
			ws_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			ws_eff = ws_ext[CNT_W-1:0];
		end
	end

	assign cnt_inc = (cnt_q == CNT_W'(WINDOW_DEPTH)) ? cnt_q : cnt_q + CNT_W'(1);
	assign produce = (cnt_inc >= ws_eff);

	for (genvar i = 0; i < N_CELL; i++) begin : g_cell
		assign cell_ctl[i].shift = accept;
		assign cell_ctl[i].tap   = (ws_eff == CNT_W'(i + 2));

		swm_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[i]),
			.x       (x),
			.prev_m  ((i == 0) ? x : cell_m[(i == 0) ? 0 : i - 1]),
			.m       (cell_m[i]),
			.tap_val (cell_tap[i])
		);
	end

	// At most one cell is tapped.
	always_comb begin
		tap_or = '0;
		for (int i = 0; i < N_CELL; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	assign result = (ws_eff == CNT_W'(1)) ? x : ((x > tap_or) ? x : tap_or);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			ws_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			cnt_q       <= in_data.last_sample ? '0 : cnt_inc;
			out_valid_q <= produce;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.window_max <= result;
			out_data_q.seq_end    <= in_data.last_sample;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/core/swm_cell.sv @@
// One chain cell: holds the maximum of the newest samples up to its position.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
	input  wire                    clk,
	input  swm_pkg::swm_cell_ctl_t ctl,
	input  swm_pkg::sample_t       x,
	input  swm_pkg::sample_t       prev_m,
	output swm_pkg::sample_t       m,
	output swm_pkg::sample_t       tap_val
);
	import swm_pkg::*;

	sample_t m_q;

	// New maximum over one more sample: the incoming sample against the neighbor's span.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			m_q <= (x > prev_m) ? x : prev_m;
		end
	end

	assign m       = m_q;
	assign tap_val = ctl.tap ? m_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/swm_checker.sv @@
// Port-level assertions for the sliding window maximum, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module swm_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      cfg_we,
	input wire [swm_pkg::CFG_W-1:0] cfg_wdata,
	input wire                      in_valid,
	input wire                      in_ready,
	input swm_pkg::swm_in_t         in_data,
	input wire                      out_valid,
	input wire                      out_ready,
	input swm_pkg::swm_out_t        out_data
);
	import swm_pkg::*;

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without a sample transfer");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result repeated after transfer");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind sliding_window_max swm_checker u_swm_checker (.*);

`default_nettype wire
